@@ sv/alubs_pkg.sv @@
// Package: widths, operation codes and flag positions for the ALU and barrel shifter.
`default_nettype none

package alubs_pkg;

  localparam int DataWidth = 32;
  localparam int ShAmtWidth = 5;
  localparam int FlagWidth = 4;

  localparam int FlagN = 3;
  localparam int FlagZ = 2;
  localparam int FlagC = 1;
  localparam int FlagV = 0;

  typedef logic [DataWidth-1:0] data_t;
  typedef logic [FlagWidth-1:0] flags_t;

  typedef enum logic {
    CMD_SHIFT = 1'b0,
    CMD_ALU   = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    SH_LSL = 4'd0,
    SH_LSR = 4'd1,
    SH_ASR = 4'd2,
    SH_ROR = 4'd3
  } shift_op_t;

  typedef enum logic [3:0] {
    ALU_AND = 4'd0,
    ALU_EOR = 4'd1,
    ALU_SUB = 4'd2,
    ALU_RSB = 4'd3,
    ALU_ADD = 4'd4,
    ALU_ORR = 4'd5,
    ALU_MOV = 4'd6,
    ALU_TST = 4'd7,
    ALU_TEQ = 4'd8,
    ALU_CMP = 4'd9
  } alu_op_t;

endpackage

`default_nettype wire

@@ sv/alu_and_barrel_shifter_with_flags_unit.sv @@
// Top level: ALU and barrel shifter with N, Z, C, V condition flags.
`default_nettype none

// Takes one request per cycle while in_stall is low and returns one result per request.
// A request is captured in an input register; the shifter, adder and flag logic sit
// between that register and the result register, and the 4-bit flag register is updated
// as the request moves into the result register, so back-to-back requests see each
// other's flags with no bubble. Shifts use the low five bits of operand b; a shift with
// set_flags can only set C. Compare and test operations, and unused codes, return a
// zero result with result_written low.
module alu_and_barrel_shifter_with_flags_unit
  import alubs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_command,
  input  wire logic [3:0]           in_operation,
  input  wire logic [DataWidth-1:0] in_operand_a,
  input  wire logic [DataWidth-1:0] in_operand_b,
  input  wire logic                 in_set_flags,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [DataWidth-1:0]      out_result,
  output logic                      out_result_written,
  output logic [FlagWidth-1:0]      out_flags
);

  logic                  s1_valid_r;
  logic                  s1_cmd_r;
  logic [3:0]            s1_op_r;
  data_t                 s1_a_r;
  data_t                 s1_b_r;
  logic                  s1_set_r;

  logic                  out_valid_r;
  data_t                 out_result_r;
  logic                  out_written_r;
  flags_t                out_flags_r;
  flags_t                flags_r;

  logic                  adv;
  logic                  load;

  data_t                 result_nxt;
  logic                  written_nxt;
  flags_t                flags_nxt;

  logic [ShAmtWidth-1:0] sh_amt;
  logic [DataWidth:0]    lsl_ext;
  logic [DataWidth:0]    lsr_ext;
  logic [DataWidth:0]    asr_ext;
  logic [2*DataWidth-1:0] ror_ext;
  logic [DataWidth:0]    add_sum;
  logic [DataWidth:0]    sub_ab;
  logic [DataWidth:0]    sub_ba;
  data_t                 sh_res;
  logic                  sh_carry;
  logic                  sh_known;
  data_t                 alu_val;
  logic                  alu_carry;
  logic                  alu_arith;
  logic                  alu_known;
  logic                  alu_setf;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign load     = !in_stall;

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_result_written = out_written_r;
  assign out_flags          = out_flags_r;

  assign sh_amt  = s1_b_r[ShAmtWidth-1:0];
  assign lsl_ext = {1'b0, s1_a_r} << sh_amt;
  assign lsr_ext = {s1_a_r, 1'b0} >> sh_amt;
  assign asr_ext = $unsigned($signed({s1_a_r, 1'b0}) >>> sh_amt);
  assign ror_ext = {s1_a_r, s1_a_r} >> sh_amt;
  assign add_sum = {1'b0, s1_a_r} + {1'b0, s1_b_r};
  assign sub_ab  = {1'b0, s1_a_r} + {1'b0, ~s1_b_r} + {{DataWidth{1'b0}}, 1'b1};
  assign sub_ba  = {1'b0, s1_b_r} + {1'b0, ~s1_a_r} + {{DataWidth{1'b0}}, 1'b1};

  always_comb begin
    sh_res   = '0;
    sh_carry = 1'b0;
    sh_known = 1'b1;
    case (s1_op_r)
      SH_LSL: begin
        sh_res   = lsl_ext[DataWidth-1:0];
        sh_carry = lsl_ext[DataWidth];
      end
      SH_LSR: begin
        sh_res   = lsr_ext[DataWidth:1];
        sh_carry = lsr_ext[0];
      end
      SH_ASR: begin
        sh_res   = asr_ext[DataWidth:1];
        sh_carry = asr_ext[0];
      end
      SH_ROR: begin
        sh_res   = ror_ext[DataWidth-1:0];
        sh_carry = (sh_amt != '0) && ror_ext[DataWidth-1];
      end
      default: begin
        sh_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    alu_val   = '0;
    alu_carry = 1'b0;
    alu_arith = 1'b0;
    alu_known = 1'b1;
    case (s1_op_r)
      ALU_AND, ALU_TST: alu_val = s1_a_r & s1_b_r;
      ALU_EOR, ALU_TEQ: alu_val = s1_a_r ^ s1_b_r;
      ALU_ORR:          alu_val = s1_a_r | s1_b_r;
      ALU_MOV:          alu_val = s1_b_r;
      ALU_SUB, ALU_CMP: begin
        alu_val   = sub_ab[DataWidth-1:0];
        alu_carry = sub_ab[DataWidth];
        alu_arith = 1'b1;
      end
      ALU_RSB: begin
        alu_val   = sub_ba[DataWidth-1:0];
        alu_carry = sub_ba[DataWidth];
        alu_arith = 1'b1;
      end
      ALU_ADD: begin
        alu_val   = add_sum[DataWidth-1:0];
        alu_carry = add_sum[DataWidth];
        alu_arith = 1'b1;
      end
      default: begin
        alu_known = 1'b0;
      end
    endcase
  end

  assign alu_setf = s1_set_r && alu_known && (s1_op_r != ALU_MOV);

  always_comb begin
    result_nxt  = '0;
    written_nxt = 1'b0;
    flags_nxt   = flags_r;
    if (s1_cmd_r == CMD_SHIFT) begin
      if (sh_known) begin
        result_nxt  = sh_res;
        written_nxt = 1'b1;
        if (s1_set_r && sh_carry) begin
          flags_nxt[FlagC] = 1'b1;
        end
      end
    end else begin
      written_nxt = alu_known && !(s1_op_r inside {ALU_TST, ALU_TEQ, ALU_CMP});
      result_nxt  = written_nxt ? alu_val : '0;
      if (alu_setf) begin
        flags_nxt[FlagN] = alu_val[DataWidth-1];
        flags_nxt[FlagZ] = (alu_val == '0);
        if (alu_arith) begin
          flags_nxt[FlagC] = alu_carry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (load) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      s1_cmd_r <= in_command;
      s1_op_r  <= in_operation;
      s1_a_r   <= in_operand_a;
      s1_b_r   <= in_operand_b;
      s1_set_r <= in_set_flags;
    end
    if (adv) begin
      out_result_r  <= result_nxt;
      out_written_r <= written_nxt;
      out_flags_r   <= flags_nxt;
    end
  end

`ifndef SYNTH
  a_v_never_set: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[FlagV] == 1'b0)
    else $error("V flag set");

  a_shift_keeps_nz: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (s1_cmd_r == CMD_SHIFT) |=> flags_r[FlagN:FlagZ] == $past(flags_r[FlagN:FlagZ]))
    else $error("shift changed N or Z");

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(flags_r))
    else $error("flags changed without an advancing request");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_written_r |-> out_result_r == '0)
    else $error("unwritten result not zero");
`endif

endmodule

`default_nettype wire
